/* hw/rtl/swm_pkg.sv */
// Shared types and constants for the sliding window median filter.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MED_W    = 33;
  localparam int CFG_W    = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0]    med_t;
  typedef logic [CFG_W-1:0]           cnt_t;

  // One sorted entry: its value and how many samples arrived after it.
  typedef struct packed {
    sample_t val;
    cnt_t    age;
  } swm_entry_t;

  // Link handed from a cell to its right neighbor.
  typedef struct packed {
    logic       rm_upto;
    logic       lt;
    swm_entry_t ent;
  } swm_link_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic    upd;
    logic    full;
    cnt_t    oldest_age;
    sample_t sample;
  } swm_ctrl_t;

endpackage

/* hw/rtl/swm_in_if.sv */
// Input channel: one sample and its restart flag per beat.
interface swm_in_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

/* hw/rtl/swm_out_if.sv */
// Result channel: twice the window median per beat.
interface swm_out_if import swm_pkg::*; ();
  logic valid;
  logic ready;
  med_t median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink (input valid, input median_doubled, output ready);
endinterface

/* hw/rtl/swm_cell.sv */
// One cell of the sorted row: holds a sample and its age, shifts with its neighbors.
module swm_cell import swm_pkg::*; (
  input  logic       clk,
  input  swm_ctrl_t  ctrl,
  input  logic       valid,
  input  logic       cvalid,
  input  swm_link_t  left,
  input  swm_entry_t right,
  output swm_link_t  fwd,
  output swm_entry_t st
);

  swm_entry_t st_r;
  swm_entry_t st_nxt;
  swm_entry_t comp;
  logic       hit;
  logic       rm_upto;
  logic       lt;

  // Drop the oldest entry by closing the gap, then open a slot for the new sample.
  always_comb begin
    hit     = valid & ctrl.full & (st_r.age == ctrl.oldest_age);
    rm_upto = left.rm_upto | hit;
    comp    = rm_upto ? right : st_r;
    lt      = cvalid & ($signed(comp.val) <= $signed(ctrl.sample));
    if (lt) begin
      st_nxt.val = comp.val;
      st_nxt.age = comp.age + CFG_W'(1);
    end else if (left.lt) begin
      st_nxt.val = ctrl.sample;
      st_nxt.age = '0;
    end else begin
      st_nxt.val = left.ent.val;
      st_nxt.age = left.ent.age + CFG_W'(1);
    end
  end

  // Payload register, written once per accepted beat.
  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      st_r <= st_nxt;
    end
  end

  assign fwd.rm_upto = rm_upto;
  assign fwd.lt      = lt;
  assign fwd.ent     = comp;
  assign st          = st_r;

endmodule

/* hw/rtl/sliding_window_median.sv */
// Top level of the running median filter: control, row of sorting cells, result register.
// Path: an accepted sample beat writes the cells and the pending flag (med_pend_r); the
// median is then loaded into the result register (out_med_r) and offered on out_ch.
// Throughput: one sample beat per cycle; each cell drops the oldest entry and inserts the
// new sample in one write of its register. The input stalls only while a median waits
// behind a stalled result beat.
// Reset clears the fill count and sets window_size to 1; cell contents are not cleared.
// A write to window_size or a beat with restart set empties the window.
module sliding_window_median import swm_pkg::*; #(
  parameter int WINDOW_MAX = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  swm_in_if.sink         in_ch,
  swm_out_if.source      out_ch
);

  localparam int   CNT_TOP = (1 << CFG_W) - 1;
  localparam int   KCAP    = (WINDOW_MAX < CNT_TOP) ? WINDOW_MAX : CNT_TOP;
  localparam cnt_t KCAP_C  = cnt_t'(KCAP);

  cnt_t       ws_r;
  cnt_t       cnt_r;
  logic       med_pend_r;
  logic       out_valid_r;
  med_t       out_med_r;

  cnt_t       k;
  cnt_t       cnt_eff;
  cnt_t       keep;
  cnt_t       cnt_nxt;
  logic       full;
  logic       emit;
  logic       in_acc;
  logic       advance;
  cnt_t       lo_idx;
  cnt_t       hi_idx;
  sample_t    lo_val;
  sample_t    hi_val;
  med_t       med_sum;
  swm_ctrl_t  ctrl;

  logic       vld  [WINDOW_MAX];
  logic       cvld [WINDOW_MAX];
  swm_entry_t st   [WINDOW_MAX];
  swm_entry_t rgt  [WINDOW_MAX];
  swm_link_t  lnk  [WINDOW_MAX+1];

  // Effective window size, limited to 1..KCAP.
  always_comb begin
    if (ws_r == '0) begin
      k = cnt_t'(1);
    end else if (ws_r > KCAP_C) begin
      k = KCAP_C;
    end else begin
      k = ws_r;
    end
  end

  // Fill bookkeeping for the beat on the input channel.
  assign cnt_eff = in_ch.restart ? '0 : cnt_r;
  assign full    = (cnt_eff >= k);
  assign keep    = full ? (k - CFG_W'(1)) : cnt_eff;
  assign cnt_nxt = keep + CFG_W'(1);
  assign emit    = (cnt_nxt == k);

  // The row may shift unless a finished median is still waiting for the output register.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !med_pend_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign ctrl.upd        = in_acc;
  assign ctrl.full       = full;
  assign ctrl.oldest_age = k - CFG_W'(1);
  assign ctrl.sample     = in_ch.sample;

  // Left boundary: the new sample goes first unless some entry is not above it.
  assign lnk[0].rm_upto = 1'b0;
  assign lnk[0].lt      = 1'b1;
  assign lnk[0].ent     = '0;

  // Row of cells, each linked to its two neighbors.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign vld[i]  = (int'(cnt_eff) > i);
    assign cvld[i] = (int'(keep) > i);
    if (i == WINDOW_MAX - 1) begin : g_last
      assign rgt[i] = '0;
    end else begin : g_mid
      assign rgt[i] = st[i+1];
    end
    swm_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .valid  (vld[i]),
      .cvalid (cvld[i]),
      .left   (lnk[i]),
      .right  (rgt[i]),
      .fwd    (lnk[i+1]),
      .st     (st[i])
    );
  end

  // Middle taps of the sorted row; for an odd window both taps are the same cell.
  assign hi_idx = k >> 1;
  assign lo_idx = k[0] ? hi_idx : (hi_idx - CFG_W'(1));

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (int'(lo_idx) == i) begin
        lo_val = lo_val | st[i].val;
      end
      if (int'(hi_idx) == i) begin
        hi_val = hi_val | st[i].val;
      end
    end
    med_sum = MED_W'(lo_val) + MED_W'(hi_val);
  end

  // Configuration, fill count and result pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= cnt_t'(1);
      cnt_r       <= '0;
      med_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ws_r  <= cfg_wdata;
        cnt_r <= '0;
      end else if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
      if (in_acc) begin
        med_pend_r <= emit;
      end else if (advance) begin
        med_pend_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= med_pend_r;
      end
    end
  end

  // Result payload, loaded when the pending median moves forward.
  always_ff @(posedge clk) begin
    if (advance && med_pend_r) begin
      out_med_r <= med_sum;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = out_med_r;

  // The fill count never passes the window size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= k)
    else $error("fill count above window size");

  // Input is held off only by a pending median behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (med_pend_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

  // A beat that fills the window leaves a median pending.
  a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> med_pend_r)
    else $error("result lost after window filled");

  // A pending median that may move forward is offered on the next cycle.
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    (med_pend_r && advance) |=> out_valid_r)
    else $error("pending median not offered");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the sliding window median filter.
module tb_top;
  import swm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 400;
  localparam int LONG_HOLD = 100;

  localparam sample_t S_MAX = {1'b0, {31{1'b1}}};
  localparam sample_t S_MIN = {1'b1, {31{1'b0}}};
  localparam med_t M_TWO_MAX = 33'h0_FFFF_FFFE;
  localparam med_t M_TWO_MIN = 33'h1_0000_0000;
  localparam med_t M_NEG_ONE = 33'h1_FFFF_FFFF;
  localparam med_t M_NEG_TWO = 33'h1_FFFF_FFFE;

  // One row of the directed stimulus: either a window size write or a sample beat.
  typedef struct {
    bit      is_cfg;
    cnt_t    cfg_val;
    sample_t sample;
    bit      restart;
    bit      want_res;
    med_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  sliding_window_median #(.WINDOW_MAX(WIN_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the filter state used to work out the expected medians.
  cnt_t    win_cfg = cnt_t'(1);
  sample_t arrival_q [WIN_MAX];
  sample_t sorted_q [WIN_MAX];
  int      fill = 0;
  int      oldest = 0;

  med_t      medians_due[$];
  stim_row_t dir_rows[$];

  int  errors = 0;
  int  medians_seen = 0;
  int  beats_sent = 0;
  int  settings_used = 0;
  int  burst_left = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  int  idle_cycles = 0;

  logic in_fire, out_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always #10 clk = ~clk;

  // Insert a value at its sorted position among the first fill entries.
  function automatic void sorted_put(sample_t v);
    int pos;
    pos = fill;
    while (pos > 0 && sorted_q[pos-1] > v) begin
      sorted_q[pos] = sorted_q[pos-1];
      pos--;
    end
    sorted_q[pos] = v;
  endfunction

  // Drop one entry equal to v from the first n sorted entries.
  function automatic void sorted_drop(sample_t v, int n);
    int pos;
    pos = 0;
    while (pos + 1 < n && sorted_q[pos] != v) pos++;
    while (pos + 1 < n) begin
      sorted_q[pos] = sorted_q[pos+1];
      pos++;
    end
  endfunction

  // Advance the shadow state by one sample; returns 1 when a median is due.
  function automatic bit predict_median(sample_t v, bit restart, output med_t med);
    int k;
    int slot;
    sample_t lo, hi;
    med = '0;
    k = int'(win_cfg);
    if (k < 1) k = 1;
    if (k > WIN_MAX) k = WIN_MAX;
    if (restart) begin
      fill = 0;
      oldest = 0;
    end
    if (fill < k) begin
      arrival_q[(oldest + fill) % k] = v;
      sorted_put(v);
      fill++;
      if (fill < k) return 1'b0;
    end else begin
      slot = oldest % k;
      sorted_drop(arrival_q[slot], k);
      fill = k - 1;
      sorted_put(v);
      fill = k;
      arrival_q[slot] = v;
      oldest = (slot + 1) % k;
    end
    // For an odd window both middle values are the same entry.
    if (k % 2 == 1) begin
      lo = sorted_q[k/2];
      hi = sorted_q[k/2];
    end else begin
      lo = sorted_q[k/2-1];
      hi = sorted_q[k/2];
    end
    med = {lo[31], lo} + {hi[31], hi};
    return 1'b1;
  endfunction

  function automatic void add_beat(sample_t s, bit rs, bit want_res, med_t want);
    stim_row_t r;
    r.is_cfg = 0;
    r.cfg_val = '0;
    r.sample = s;
    r.restart = rs;
    r.want_res = want_res;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(cnt_t v);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.cfg_val = v;
    dir_rows.push_back(r);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return ($urandom_range(0, 1) != 0) ? sample_t'(0) : sample_t'(-1);
      3, 4, 5: return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Sender pacing: bursts of random length, separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = quiet ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Offer one beat and, once it is taken, record the median it should cause.
  task automatic send_sample(input sample_t s, input bit rs, input bit typed,
                             input bit want_res, input med_t want);
    med_t med;
    bit   due;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    due = predict_median(s, rs, med);
    if (typed) begin
      due = want_res;
      med = want;
    end
    if (due) medians_due.push_back(med);
    beats_sent++;
  endtask

  // Write the window size once the filter has drained.
  task automatic write_window(input cnt_t val);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    // A beat that causes no median may still be in flight.
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_cfg = val;
    fill = 0;
    oldest = 0;
    settings_used++;
  endtask

  // Compare each result beat with the oldest expected median.
  always @(posedge clk) begin
    med_t exp_med;
    if (rst_n && out_fire) begin
      if (medians_due.size() == 0) begin
        $error("median_doubled: no result expected, actual %0d", out_ch.median_doubled);
        errors++;
      end else begin
        exp_med = medians_due.pop_front();
        medians_seen++;
        if (out_ch.median_doubled !== exp_med) begin
          $error("median_doubled: expected %0d, actual %0d", exp_med,
                 out_ch.median_doubled);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: stall patterns chosen at random, each held for a random span, plus one long hold.
  initial begin : rx_pacer
    int mode;
    int left;
    int hold;
    logic [7:0] mask;
    mode = 0;
    left = 0;
    hold = 0;
    mask = '1;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 80);
          mask = 8'($urandom) | 8'h01;
        end
        left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= mask[left % 8];
        endcase
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain and report.
  initial begin : main_seq
    int phase;
    int n;
    int rand_beats;
    int directed_beats;
    cnt_t sz;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.restart = 1'b0;
    phase = 0;
    rand_beats = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Window of one after reset: each sample is its own median.
    add_beat(S_MAX, 0, 1, M_TWO_MAX);
    add_beat(S_MIN, 0, 1, M_TWO_MIN);
    add_beat(-1, 1, 1, M_NEG_TWO);
    // A size of zero acts as a window of one.
    add_cfg(cnt_t'(0));
    add_beat(5, 0, 1, med_t'(10));
    // Window of two with duplicates and a restart in the middle.
    add_cfg(cnt_t'(2));
    add_beat(S_MAX, 0, 0, '0);
    add_beat(S_MAX, 0, 1, M_TWO_MAX);
    add_beat(S_MIN, 0, 1, M_NEG_ONE);
    add_beat(3, 1, 0, '0);
    add_beat(7, 0, 1, med_t'(10));
    // An oversize setting is limited to the largest window.
    add_cfg(cnt_t'(31));
    for (int i = 0; i < WIN_MAX; i++) begin
      add_beat((i % 2 == 0) ? S_MAX : S_MIN, 0, i == WIN_MAX - 1,
               (i == WIN_MAX - 1) ? M_NEG_ONE : med_t'(0));
    end

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_window(dir_rows[i].cfg_val);
      end else begin
        pace_sender();
        send_sample(dir_rows[i].sample, dir_rows[i].restart, 1,
                    dir_rows[i].want_res, dir_rows[i].want);
      end
    end
    directed_beats = beats_sent;

    // Random phases, each with its own window size and sender pacing.
    while (rand_beats < RANDOM_BEATS) begin
      case ($urandom_range(0, 7))
        0: sz = cnt_t'(0);
        1: sz = cnt_t'(1);
        2: sz = cnt_t'(2);
        3: sz = cnt_t'(WIN_MAX);
        4: sz = cnt_t'(31);
        5: sz = cnt_t'($urandom_range(WIN_MAX + 1, 30));
        default: sz = cnt_t'($urandom_range(3, WIN_MAX - 1));
      endcase
      // The second phase runs a window of one against a long receiver hold.
      if (phase == 1) sz = cnt_t'(1);
      write_window(sz);
      quiet = ($urandom_range(0, 3) == 0) || (phase == 1);
      burst_left = 0;
      if (phase == 1) hold_req = 1;
      n = $urandom_range(15, 50);
      for (int i = 0; i < n; i++) begin
        pace_sender();
        send_sample(pick_sample(), $urandom_range(0, 24) == 0, 0, 0, '0);
        rand_beats++;
      end
      phase++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d sample beats (%0d directed) over %0d window settings,",
             beats_sent, directed_beats, settings_used);
    $display("with %0d medians checked and %0d errors.", medians_seen, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
